// ----- hw/rtl/c_subset_lexer_defines.svh -----
// Assertion macros shared by the lexer RTL.
// Depends on nothing; callers provide clk and rst_n in scope.
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CLX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/clx_pkg.sv -----
// Types, constants and helper functions for the C subset lexer.
// Depends on nothing; used by every lexer file except the assertion macro header.
package clx_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 8;
  localparam int OFFSET_BITS = 24;
  localparam int KIND_BITS   = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_BITS-1:0] KIND_EOF    = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_IDENT  = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_INT    = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_RETURN = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_STRING = 6'd5;
  localparam logic [KIND_BITS-1:0] KIND_CHAR   = 6'd6;
  localparam logic [KIND_BITS-1:0] KIND_EQ     = 6'd7;
  localparam logic [KIND_BITS-1:0] KIND_NE     = 6'd8;
  localparam logic [KIND_BITS-1:0] KIND_LE     = 6'd9;
  localparam logic [KIND_BITS-1:0] KIND_GE     = 6'd10;
  localparam logic [KIND_BITS-1:0] KIND_ARROW  = 6'd11;
  localparam logic [KIND_BITS-1:0] KIND_NONE   = 6'd0;

  // keyword_match states: "int" ends at 3, "return" ends at 9
  localparam logic [3:0] KW_INT_DONE    = 4'd3;
  localparam logic [3:0] KW_RETURN_DONE = 4'd9;
  localparam logic [3:0] KW_INT_START   = 4'd1;
  localparam logic [3:0] KW_RET_START   = 4'd4;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_CHAR,
    MODE_BLOCK, MODE_BLOCK_STAR, MODE_LINE, MODE_OP
  } clx_mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_source;
  } clx_in_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   token_kind;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [LENGTH_BITS-1:0] token_length;
    logic [OFFSET_BITS-1:0] start_offset;
    logic                   last;
  } clx_token_t;

  // One or two tokens caused by one source byte
  typedef struct packed {
    logic       two;
    clx_token_t tok0;
    clx_token_t tok1;
  } clx_bundle_t;

  typedef struct packed {
    clx_mode_t mode;
  } clx_scan_status_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 full;
  } clx_queue_status_t;

  function automatic logic [7:0] kw_next(input logic [3:0] km);
    unique case (km)
      4'd1:    kw_next = 8'h6E; // n
      4'd2:    kw_next = 8'h74; // t
      4'd4:    kw_next = 8'h65; // e
      4'd5:    kw_next = 8'h74; // t
      4'd6:    kw_next = 8'h75; // u
      4'd7:    kw_next = 8'h72; // r
      4'd8:    kw_next = 8'h6E; // n
      default: kw_next = 8'h00;
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
    unique case (b)
      8'h7B: single_kind = 6'd12; // {
      8'h7D: single_kind = 6'd13; // }
      8'h28: single_kind = 6'd14; // (
      8'h29: single_kind = 6'd15; // )
      8'h5B: single_kind = 6'd16; // [
      8'h5D: single_kind = 6'd17; // ]
      8'h3B: single_kind = 6'd18; // ;
      8'h2C: single_kind = 6'd19; // ,
      8'h2E: single_kind = 6'd20; // .
      8'h3D: single_kind = 6'd21; // =
      8'h2B: single_kind = 6'd22; // +
      8'h2D: single_kind = 6'd23; // -
      8'h2A: single_kind = 6'd24; // *
      8'h2F: single_kind = 6'd25; // /
      8'h25: single_kind = 6'd26; // %
      8'h26: single_kind = 6'd27; // &
      8'h7C: single_kind = 6'd28; // |
      8'h5E: single_kind = 6'd29; // ^
      8'h7E: single_kind = 6'd30; // ~
      8'h21: single_kind = 6'd31; // !
      8'h3F: single_kind = 6'd32; // ?
      8'h3A: single_kind = 6'd33; // :
      8'h3C: single_kind = 6'd34; // <
      8'h3E: single_kind = 6'd35; // >
      8'h23: single_kind = 6'd36; // #
      default: single_kind = KIND_NONE;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

// ----- hw/rtl/clx_stream_if.sv -----
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on clx_pkg for the payload types.
interface clx_in_if;
  logic             valid;
  logic             ready;
  clx_pkg::clx_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface clx_out_if;
  logic                valid;
  logic                ready;
  clx_pkg::clx_token_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/c_subset_lexer.sv -----
// Top level of the C subset lexer: scanner, bundle queue, token emitter.
// Depends on clx_pkg, clx_stream_if, clx_scanner, clx_queue, clx_emitter.
//
//   channel   direction  payload
//   in_ch     sink       char_byte, end_of_source (one source byte per word)
//   out_ch    source     token_kind, start_line, start_column, token_length,
//                        start_offset, last (one token per word)
//
// A source byte is taken every cycle while the bundle queue has room; each
// byte yields zero, one or two tokens, and the emitter hands out one token
// per cycle while out_ch is ready, so a two-token bundle leaves as two words.
// A byte's tokens pass through a queue slot, then through the output register.
// Reset is synchronous, active low; scanner state returns to line 1, column 1.
// A stalled output fills the queue, then drops in_ch.ready; the scanner holds.
`include "c_subset_lexer_defines.svh"

module c_subset_lexer (
  input  logic      clk,
  input  logic      rst_n,
  clx_in_if.sink    in_ch,
  clx_out_if.source out_ch
);
  import clx_pkg::*;

  logic              accept, push, pop, head_valid;
  clx_bundle_t       push_bundle, head_bundle;
  clx_scan_status_t  scan_status;
  clx_queue_status_t queue_status;

  // Take a byte only when its bundle is sure to fit
  assign in_ch.ready = !queue_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  clx_scanner u_scanner (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_ch.payload),
    .push    (push),
    .bundle  (push_bundle),
    .status  (scan_status)
  );

  clx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_bundle),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_bundle),
    .status     (queue_status)
  );

  clx_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_bundle),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_token  (out_ch.payload)
  );

  // End of source always leaves the scanner between tokens
  `CLX_ASSERT_NEXT(a_eos_idle, accept && in_ch.payload.end_of_source, scan_status.mode == MODE_IDLE, "scanner not idle after end of source")
  // The queue never holds more than its depth
  `CLX_ASSERT_NOW(a_queue_bound, 1'b1, queue_status.count <= QCNT_BITS'(QUEUE_DEPTH), "queue overfilled")
  // Only an EOF token closes a source
  `CLX_ASSERT_NOW(a_last_is_eof, out_ch.valid && out_ch.payload.last, out_ch.payload.token_kind == KIND_EOF && out_ch.payload.token_length == '0, "last flag on non-EOF token")

endmodule

// ----- hw/rtl/clx_scanner.sv -----
// Front part: scans one source byte per cycle while accept is high and forms token bundles.
// Depends on clx_pkg.
module clx_scanner (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  clx_pkg::clx_in_t      in_data,
  output logic                  push,
  output clx_pkg::clx_bundle_t  bundle,
  output clx_pkg::clx_scan_status_t status
);
  import clx_pkg::*;

  clx_mode_t              mode_r, mode_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [LINE_BITS-1:0]   tsl_r, tsl_nxt;
  logic [COLUMN_BITS-1:0] tsc_r, tsc_nxt;
  logic [OFFSET_BITS-1:0] tso_r, tso_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [3:0]             km_r, km_nxt;
  logic [1:0]             step_r, step_nxt;

  logic                   flush_has;
  logic [KIND_BITS-1:0]   flush_kind;
  logic [LENGTH_BITS-1:0] flush_len, len_grown;
  logic                   emit_a, emit_b, rescan, do_flush, finish;
  logic [KIND_BITS-1:0]   kind_a, pair_kind;
  logic [LENGTH_BITS-1:0] len_a;
  clx_token_t             tok_a, tok_b;
  logic [7:0]             b;

  assign b         = in_data.char_byte;
  assign finish    = in_data.end_of_source || (b == 8'h00);
  assign len_grown = (len_r == '1) ? len_r : len_r + 1'b1;

  // What the pending token looks like if cut off here
  always_comb begin
    flush_has  = 1'b1;
    flush_len  = len_r;
    flush_kind = KIND_NONE;
    unique case (mode_r)
      MODE_IDENT:  flush_kind = (km_r == KW_INT_DONE) ? KIND_INT :
                                (km_r == KW_RETURN_DONE) ? KIND_RETURN : KIND_IDENT;
      MODE_NUMBER: flush_kind = KIND_NUMBER;
      MODE_STRING: flush_kind = KIND_STRING;
      MODE_CHAR:   flush_kind = KIND_CHAR;
      MODE_OP: begin
        flush_kind = single_kind(pend_r);
        flush_len  = LENGTH_BITS'(1);
      end
      default:     flush_has = 1'b0;
    endcase
  end

  // Two-character operator formed by the pending byte and this byte
  always_comb begin
    pair_kind = KIND_NONE;
    if (b == 8'h3D) begin
      priority case (pend_r)
        8'h3D:   pair_kind = KIND_EQ;
        8'h21:   pair_kind = KIND_NE;
        8'h3C:   pair_kind = KIND_LE;
        8'h3E:   pair_kind = KIND_GE;
        default: pair_kind = KIND_NONE;
      endcase
    end else if (b == 8'h3E && pend_r == 8'h2D) begin
      pair_kind = KIND_ARROW;
    end
  end

  always_comb begin
    mode_nxt = mode_r;  pend_nxt = pend_r;
    line_nxt = line_r;  col_nxt  = col_r;  off_nxt = off_r;
    tsl_nxt  = tsl_r;   tsc_nxt  = tsc_r;  tso_nxt = tso_r;
    len_nxt  = len_r;   km_nxt   = km_r;   step_nxt = step_r;
    emit_a = 1'b0; kind_a = KIND_NONE; len_a = len_r;
    emit_b = 1'b0; rescan = 1'b0; do_flush = 1'b0;
    tok_b  = '{token_kind: KIND_EOF, start_line: line_r, start_column: col_r,
               token_length: '0, start_offset: off_r, last: 1'b0};

    if (finish) begin
      emit_a = flush_has; kind_a = flush_kind; len_a = flush_len;
      emit_b = 1'b1;
      tok_b.last = 1'b1;
      mode_nxt = MODE_IDLE; pend_nxt = '0;
      line_nxt = LINE_BITS'(1); col_nxt = COLUMN_BITS'(1); off_nxt = '0;
      tsl_nxt = LINE_BITS'(1); tsc_nxt = COLUMN_BITS'(1); tso_nxt = '0;
      len_nxt = '0; km_nxt = '0; step_nxt = '0;
    end else begin
      unique case (mode_r)
        MODE_IDENT: begin
          if (is_alpha(b) || is_digit(b) || b == 8'h5F) begin
            len_nxt = len_grown;
            km_nxt  = (kw_next(km_r) != 8'h00 && kw_next(km_r) == b) ? km_r + 4'd1 : 4'd0;
          end else begin
            do_flush = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(b)) len_nxt = len_grown;
          else do_flush = 1'b1;
        end
        MODE_STRING: begin
          len_nxt = len_grown;
          if (b == 8'h22) begin
            emit_a = 1'b1; kind_a = KIND_STRING; len_a = len_grown;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_CHAR: begin
          if (step_r == 2'd0) begin
            len_nxt  = len_grown;
            step_nxt = (b == 8'h5C) ? 2'd1 : 2'd2;
          end else if (step_r == 2'd1) begin
            len_nxt  = len_grown;
            step_nxt = 2'd2;
          end else if (b == 8'h27) begin
            len_nxt = len_grown;
            emit_a = 1'b1; kind_a = KIND_CHAR; len_a = len_grown;
            mode_nxt = MODE_IDLE; step_nxt = 2'd0;
          end else begin
            do_flush = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (b == 8'h2A) mode_nxt = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (b == 8'h2F) mode_nxt = MODE_IDLE;
          else if (b != 8'h2A) mode_nxt = MODE_BLOCK;
        end
        MODE_LINE: begin
          if (b == 8'h0A) mode_nxt = MODE_IDLE;
        end
        MODE_OP: begin
          if (pend_r == 8'h2F && (b == 8'h2A || b == 8'h2F)) begin
            mode_nxt = (b == 8'h2A) ? MODE_BLOCK : MODE_LINE;
          end else if (pair_kind != KIND_NONE) begin
            emit_a = 1'b1; kind_a = pair_kind; len_a = LENGTH_BITS'(2);
            mode_nxt = MODE_IDLE;
          end else begin
            do_flush = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      if (do_flush) begin
        emit_a = flush_has; kind_a = flush_kind; len_a = flush_len;
        mode_nxt = MODE_IDLE; km_nxt = '0; step_nxt = '0;
        rescan = 1'b1;
      end

      // Look at the byte afresh from between tokens
      if (rescan) begin
        if (is_space(b)) begin
          mode_nxt = MODE_IDLE;
        end else if (b == 8'h22 || b == 8'h27 || is_digit(b) || is_alpha(b) ||
                     b == 8'h5F || b == 8'h2F || b == 8'h3D || b == 8'h21 ||
                     b == 8'h3C || b == 8'h3E || b == 8'h2D) begin
          tsl_nxt = line_r; tsc_nxt = col_r; tso_nxt = off_r;
          len_nxt = LENGTH_BITS'(1);
          if (b == 8'h22) begin
            mode_nxt = MODE_STRING;
          end else if (b == 8'h27) begin
            mode_nxt = MODE_CHAR; step_nxt = 2'd0;
          end else if (is_digit(b)) begin
            mode_nxt = MODE_NUMBER;
          end else if (is_alpha(b) || b == 8'h5F) begin
            mode_nxt = MODE_IDENT;
            km_nxt = (b == 8'h69) ? KW_INT_START : (b == 8'h72) ? KW_RET_START : 4'd0;
          end else begin
            mode_nxt = MODE_OP; pend_nxt = b;
          end
        end else if (single_kind(b) != KIND_NONE) begin
          emit_b = 1'b1;
          tok_b.token_kind   = single_kind(b);
          tok_b.token_length = LENGTH_BITS'(1);
        end
      end

      if (b == 8'h0A) begin
        line_nxt = (line_r == '1) ? line_r : line_r + 1'b1;
        col_nxt  = COLUMN_BITS'(1);
      end else begin
        col_nxt  = (col_r == '1) ? col_r : col_r + 1'b1;
      end
      off_nxt = (off_r == '1) ? off_r : off_r + 1'b1;
    end
  end

  assign tok_a = '{token_kind: kind_a, start_line: tsl_r, start_column: tsc_r,
                   token_length: len_a, start_offset: tso_r, last: 1'b0};

  assign push        = accept && (emit_a || emit_b);
  assign bundle.two  = emit_a && emit_b;
  assign bundle.tok0 = emit_a ? tok_a : tok_b;
  assign bundle.tok1 = tok_b;
  assign status.mode = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE; pend_r <= '0;
      line_r <= LINE_BITS'(1); col_r <= COLUMN_BITS'(1); off_r <= '0;
      tsl_r <= LINE_BITS'(1); tsc_r <= COLUMN_BITS'(1); tso_r <= '0;
      len_r <= '0; km_r <= '0; step_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt; pend_r <= pend_nxt;
      line_r <= line_nxt; col_r <= col_nxt; off_r <= off_nxt;
      tsl_r <= tsl_nxt; tsc_r <= tsc_nxt; tso_r <= tso_nxt;
      len_r <= len_nxt; km_r <= km_nxt; step_r <= step_nxt;
    end
  end

endmodule

// ----- hw/rtl/clx_queue.sv -----
// Short bundle queue between scanner and token emitter.
// Depends on clx_pkg.
module clx_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  clx_pkg::clx_bundle_t      push_data,
  input  logic                      pop,
  output logic                      head_valid,
  output clx_pkg::clx_bundle_t      head_data,
  output clx_pkg::clx_queue_status_t status
);
  import clx_pkg::*;

  clx_bundle_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign status.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign status.count = cnt_r;
  assign head_valid   = (cnt_r != '0);
  assign head_data    = slot_r[rd_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    if (do_push) wr_nxt = (wr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt; rd_r <= rd_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_data;
  end

endmodule

// ----- hw/rtl/clx_emitter.sv -----
// Back part: splits bundles into single tokens behind an output register.
// Depends on clx_pkg.
module clx_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  clx_pkg::clx_bundle_t head_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output clx_pkg::clx_token_t  out_token
);
  import clx_pkg::*;

  logic       valid_r, valid_nxt;
  logic       idx_r, idx_nxt;
  logic       load;
  clx_token_t tok_r;

  assign load = head_valid && (!valid_r || out_ready);
  assign pop  = load && (!head_data.two || idx_r);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = !pop;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0; idx_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt; idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) tok_r <= idx_r ? head_data.tok1 : head_data.tok0;
  end

  assign out_valid = valid_r;
  assign out_token = tok_r;

endmodule
